### sv/rc_knob_gain_adjuster_macros.svh
// Assertion macros used by the checker file of the knob gain adjuster.
`ifndef RC_KNOB_GAIN_ADJUSTER_MACROS_SVH
`define RC_KNOB_GAIN_ADJUSTER_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define RCKA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define RCKA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rcka_pkg.sv
package rcka_pkg;

    // Field widths.
    localparam int REQ_W     = 2;
    localparam int ENTRY_W   = 4;
    localparam int GAIN_W    = 16;
    localparam int PULSE_W   = 16;
    localparam int FLASH_W   = 4;
    localparam int MODE_W    = 2;
    localparam int ENTRY_SPAN = 2 ** ENTRY_W;

    // Default table size.
    localparam int RCKA_NUM_GAINS = 16;

    // Request kinds carried in the input tuser.
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // Decoded mode positions.
    localparam logic [MODE_W-1:0] MODE_HIGH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MID  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOW  = 2'd2;

    // Flash codes.
    localparam logic [FLASH_W-1:0] FLASH_NONE  = 4'd0;
    localparam logic [FLASH_W-1:0] FLASH_UP    = 4'd1;
    localparam logic [FLASH_W-1:0] FLASH_DOWN  = 4'd2;
    localparam logic [FLASH_W-1:0] FLASH_CLAMP = 4'd5;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESH_LOW  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESH_HIGH = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_STEP   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ADJ_INDEX_0 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ADJ_INDEX_1 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_ADJ_INDEX_2 = 3'd5;

    // Configuration reset values.
    localparam logic [PULSE_W-1:0] THRESH_LOW_RST  = 16'd2600;
    localparam logic [PULSE_W-1:0] THRESH_HIGH_RST = 16'd3400;
    localparam logic [GAIN_W-1:0]  GAIN_STEP_RST   = 16'd819;
    localparam logic [ENTRY_W-1:0] ADJ_INDEX_0_RST = 4'd0;
    localparam logic [ENTRY_W-1:0] ADJ_INDEX_1_RST = 4'd1;
    localparam logic [ENTRY_W-1:0] ADJ_INDEX_2_RST = 4'd2;

    // Knob dead band in counts and the saturation ceiling.
    localparam logic signed [PULSE_W:0] KNOB_DEADBAND = 17'sd6;
    localparam logic [GAIN_W-1:0]       GAIN_MAX      = 16'hFFFF;

    // Stream widths and result field positions.
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;
    localparam int M_VALUE_LSB   = 0;
    localparam int M_ENTRY_LSB   = 16;
    localparam int M_CHANGED_BIT = 20;
    localparam int M_FLASH_LSB   = 21;
    localparam int M_MODE_LSB    = 25;

endpackage

### sv/rc_knob_gain_adjuster.sv
// Channel   | Port group               | Contents
// ----------+--------------------------+-----------------------------------------
// request   | s_tvalid/s_tready/s_tdata| one tick, table write or table read
//           | s_tuser                  | request kind
// result    | m_tvalid/m_tready/m_tdata| one result per request
// config    | cfg_wr_en/cfg_addr/cfg_wdata | register write, no read-back
//
// One request per cycle unless stalled; it passes the input, then the result register.
// The gain table, baseline and flags are updated in the cycle a request moves from the
// input register to the result register, so the next request sees them at once.
// Reset is synchronous and active low; it clears the gain table and all control state.
// A stalled result holds; the input register holds one more request, then s_tready drops.
module rc_knob_gain_adjuster
    import rcka_pkg::*;
#(
    parameter int NUM_GAINS = RCKA_NUM_GAINS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata, lowest bit up: entry_index[3:0], write_value[19:4], link_up[20],
    // calib_done[21], mode_pulse[37:22], gain_pulse[53:38], zero[55:54]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // tuser: req_type[1:0]
    input  logic [REQ_W-1:0]      s_tuser,
    // Result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tdata, lowest bit up: gain_value[15:0], gain_entry[19:16], gain_changed[20],
    // flash_code[24:21], mode_now[26:25], zero[31:27]
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int TABLE_DEPTH = (NUM_GAINS < ENTRY_SPAN) ? NUM_GAINS : ENTRY_SPAN;
    localparam int TIDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef struct packed {
        logic [PULSE_W-1:0] gain_pulse;
        logic [PULSE_W-1:0] mode_pulse;
        logic               calib_done;
        logic               link_up;
        logic [GAIN_W-1:0]  write_value;
        logic [ENTRY_W-1:0] entry_index;
    } req_item_t;

    localparam int ITEM_W = $bits(req_item_t);

    // Configuration registers
    logic [PULSE_W-1:0] thresh_low_reg;
    logic [PULSE_W-1:0] thresh_high_reg;
    logic [GAIN_W-1:0]  gain_step_reg;
    logic [ENTRY_W-1:0] adj_index_0_reg;
    logic [ENTRY_W-1:0] adj_index_1_reg;
    logic [ENTRY_W-1:0] adj_index_2_reg;

    // Block state
    logic [GAIN_W-1:0]  gain_table_reg [TABLE_DEPTH];
    logic [PULSE_W-1:0] baseline_reg;
    logic [PULSE_W-1:0] baseline_next;
    logic               armed_reg;
    logic               armed_next;
    logic [FLASH_W-1:0] flash_reg;
    logic [FLASH_W-1:0] flash_next;
    logic [MODE_W-1:0]  mode_reg;
    logic [MODE_W-1:0]  mode_next;

    // Pipeline registers
    logic               in_valid_reg;
    req_item_t          in_item_reg;
    logic [REQ_W-1:0]   in_req_reg;
    logic               out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;

    // Datapath signals
    logic               out_free;
    logic               fire;
    logic               is_tick;
    logic [MODE_W-1:0]  mode_dec;
    logic [ENTRY_W-1:0] rep_idx;
    logic               rep_in_range;
    logic [GAIN_W-1:0]  rd_val;
    logic signed [PULSE_W:0] delta;
    logic               knob_up;
    logic               knob_down;
    logic [GAIN_W:0]    up_sum;
    logic               up_fits;
    logic               down_fits;
    logic               changed;
    logic               wr_en;
    logic [GAIN_W-1:0]  wr_val;
    logic [GAIN_W-1:0]  out_val;

    // Handshake: the result register frees when taken, the input register when it fires.
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_low_reg  <= THRESH_LOW_RST;
            thresh_high_reg <= THRESH_HIGH_RST;
            gain_step_reg   <= GAIN_STEP_RST;
            adj_index_0_reg <= ADJ_INDEX_0_RST;
            adj_index_1_reg <= ADJ_INDEX_1_RST;
            adj_index_2_reg <= ADJ_INDEX_2_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_THRESH_LOW:  thresh_low_reg  <= cfg_wdata[PULSE_W-1:0];
                CFG_THRESH_HIGH: thresh_high_reg <= cfg_wdata[PULSE_W-1:0];
                CFG_GAIN_STEP:   gain_step_reg   <= cfg_wdata[GAIN_W-1:0];
                CFG_ADJ_INDEX_0: adj_index_0_reg <= cfg_wdata[ENTRY_W-1:0];
                CFG_ADJ_INDEX_1: adj_index_1_reg <= cfg_wdata[ENTRY_W-1:0];
                CFG_ADJ_INDEX_2: adj_index_2_reg <= cfg_wdata[ENTRY_W-1:0];
                default: ;
            endcase
        end
    end

    // Mode decode from the switch pulse width.
    always_comb begin
        if (in_item_reg.mode_pulse < thresh_low_reg) begin
            mode_dec = MODE_LOW;
        end else if (in_item_reg.mode_pulse < thresh_high_reg) begin
            mode_dec = MODE_MID;
        end else begin
            mode_dec = MODE_HIGH;
        end
    end

    // Request decode: the mode after this request and the entry it reports on.
    always_comb begin
        is_tick   = (in_req_reg == REQ_TICK) && in_item_reg.link_up;
        mode_next = is_tick ? mode_dec : mode_reg;
        case (in_req_reg)
            REQ_WRITE, REQ_READ: rep_idx = in_item_reg.entry_index;
            default: begin
                case (mode_next)
                    MODE_LOW: rep_idx = adj_index_2_reg;
                    MODE_MID: rep_idx = adj_index_1_reg;
                    default:  rep_idx = adj_index_0_reg;
                endcase
            end
        endcase
    end

    // Single table read; entries beyond the table read as zero.
    assign rep_in_range = (int'(rep_idx) < NUM_GAINS);
    assign rd_val = rep_in_range ? gain_table_reg[rep_idx[TIDX_W-1:0]] : '0;

    // Knob movement against the baseline and saturating step checks.
    assign delta     = $signed({1'b0, in_item_reg.gain_pulse}) - $signed({1'b0, baseline_reg});
    assign knob_up   = (delta > KNOB_DEADBAND);
    assign knob_down = (delta < -KNOB_DEADBAND);
    assign up_sum    = {1'b0, rd_val} + {1'b0, gain_step_reg};
    assign up_fits   = (up_sum < {1'b0, GAIN_MAX});
    assign down_fits = (rd_val > gain_step_reg);

    // State update and table write for the request in the input register.
    always_comb begin
        armed_next    = armed_reg;
        baseline_next = baseline_reg;
        flash_next    = flash_reg;
        changed       = 1'b0;
        wr_en         = 1'b0;
        wr_val        = in_item_reg.write_value;
        case (in_req_reg)
            REQ_WRITE: wr_en = rep_in_range;
            REQ_READ: ;
            default: begin
                if (is_tick) begin
                    if (!armed_reg) begin
                        if (in_item_reg.calib_done) begin
                            baseline_next = in_item_reg.gain_pulse;
                            armed_next    = 1'b1;
                        end
                    end else if (knob_up || knob_down) begin
                        baseline_next = in_item_reg.gain_pulse;
                        if (rep_in_range) begin
                            changed = 1'b1;
                            wr_en   = 1'b1;
                            if (knob_up) begin
                                wr_val     = up_fits ? up_sum[GAIN_W-1:0] : GAIN_MAX;
                                flash_next = up_fits ? FLASH_UP : FLASH_CLAMP;
                            end else begin
                                wr_val     = down_fits ? (rd_val - gain_step_reg) : '0;
                                flash_next = down_fits ? FLASH_DOWN : FLASH_CLAMP;
                            end
                        end
                    end
                end
            end
        endcase
    end

    // Result assembly; the reported value is the entry after this request.
    assign out_val = wr_en ? wr_val : rd_val;
    always_comb begin
        out_data_next = '0;
        out_data_next[M_VALUE_LSB +: GAIN_W]  = out_val;
        out_data_next[M_ENTRY_LSB +: ENTRY_W] = rep_idx;
        out_data_next[M_CHANGED_BIT]          = changed;
        out_data_next[M_FLASH_LSB +: FLASH_W] = flash_next;
        out_data_next[M_MODE_LSB +: MODE_W]   = mode_next;
    end

    // Control state and the gain table.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            armed_reg     <= 1'b0;
            baseline_reg  <= '0;
            flash_reg     <= FLASH_NONE;
            mode_reg      <= MODE_HIGH;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                gain_table_reg[i] <= '0;
            end
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                armed_reg    <= armed_next;
                baseline_reg <= baseline_next;
                flash_reg    <= flash_next;
                mode_reg     <= mode_next;
                if (wr_en) begin
                    gain_table_reg[rep_idx[TIDX_W-1:0]] <= wr_val;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= req_item_t'(s_tdata[ITEM_W-1:0]);
            in_req_reg  <= s_tuser;
        end
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

### sv/rcka_checker.sv
`include "rc_knob_gain_adjuster_macros.svh"

module rcka_checker
    import rcka_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [GAIN_W-1:0]  gain_value;
    logic               gain_changed;
    logic [FLASH_W-1:0] flash_code;
    logic               stalled;
    logic               stepped;
    logic               step_coded;
    logic               clamped;
    logic               on_rail;
    logic               stepped_down;

    assign gain_value   = m_tdata[M_VALUE_LSB +: GAIN_W];
    assign gain_changed = m_tdata[M_CHANGED_BIT];
    assign flash_code   = m_tdata[M_FLASH_LSB +: FLASH_W];

    // Conditions seen on the result channel.
    assign stalled      = m_tvalid && !m_tready;
    assign stepped      = m_tvalid && gain_changed;
    assign step_coded   = (flash_code == FLASH_UP) || (flash_code == FLASH_DOWN) ||
                          (flash_code == FLASH_CLAMP);
    assign clamped      = stepped && (flash_code == FLASH_CLAMP);
    assign on_rail      = (gain_value == '0) || (gain_value == GAIN_MAX);
    assign stepped_down = stepped && (flash_code == FLASH_DOWN);

    // A result that is not taken stays, unchanged.
    `RCKA_ASSERT_NEXT(a_hold, aclk, aresetn, stalled, m_tvalid && $stable(m_tdata), "result moved")

    // A stepped gain always records one of the step outcomes.
    `RCKA_ASSERT_IMPL(a_step_code, aclk, aresetn, stepped, step_coded, "step without a step code")

    // A clamped step leaves the gain at one of its rails.
    `RCKA_ASSERT_IMPL(a_clamp_rail, aclk, aresetn, clamped, on_rail, "clamped gain off its rail")

    // An unsaturated step down always leaves something above zero.
    `RCKA_ASSERT_IMPL(a_down_nonzero, aclk, aresetn, stepped_down, gain_value != '0, "step down hit zero")

endmodule

bind rc_knob_gain_adjuster rcka_checker u_rcka_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
